// File: hw/rtl/iea_pkg.sv
// shared types and constants for the i2c eeprom access master
package iea_pkg;

  // input tdata packing: address, write_data, sda_in
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned IN_USER_W  = 2;
  // output tdata packing: scl, sda, busy, done, read_data, ack_missing
  localparam int unsigned OUT_DATA_W = 16;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_DEV_ADDR  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACK_LIMIT = 1'b1;

  localparam logic [6:0] DEV_ADDR_RST  = 7'd80;
  localparam logic [7:0] ACK_LIMIT_RST = 8'd250;

  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } cmd_kind_t;

  // one classified tick as it waits in the queue
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] address;
    logic [7:0] write_data;
    logic       sda_in;
  } tick_t;

  // queue to sequencer handshake
  typedef struct packed {
    logic  valid;
    tick_t item;
  } q_head_t;

endpackage

// File: hw/rtl/iea_front.sv
// request intake: decodes func and holds ticks in a two-entry queue
module iea_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [iea_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [iea_pkg::IN_USER_W-1:0]     in_tuser,
  output iea_pkg::q_head_t                  q_head,
  input  logic                              q_pop
);

  iea_pkg::tick_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  iea_pkg::tick_t dec;

  // unused func code behaves as a plain tick
  always_comb begin
    dec.address    = in_tdata[7:0];
    dec.write_data = in_tdata[15:8];
    dec.sda_in     = in_tdata[16];
    priority if (in_tuser == iea_pkg::FUNC_WRITE) begin
      dec.kind = iea_pkg::CMD_WRITE;
    end else if (in_tuser == iea_pkg::FUNC_READ) begin
      dec.kind = iea_pkg::CMD_READ;
    end else begin
      dec.kind = iea_pkg::CMD_TICK;
    end
  end

  assign in_tready = (count_r != 2'd2);
  assign push      = in_tvalid && in_tready;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign q_head.valid = (count_r != 2'd0);
  assign q_head.item  = mem_r[rd_ptr_r];

endmodule

// File: hw/rtl/iea_back.sv
// bus sequencer: steps the i2c phase machine once per tick and registers the result
module iea_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  iea_pkg::q_head_t                  q_head,
  output logic                              q_pop,
  input  logic                              cfg_valid,
  input  logic [iea_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [iea_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [iea_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam logic [4:0] PH_IDLE     = 5'd0;
  localparam logic [4:0] PH_ST_SDA1  = 5'd1;
  localparam logic [4:0] PH_ST_SCL1  = 5'd2;
  localparam logic [4:0] PH_ST_SDA0  = 5'd3;
  localparam logic [4:0] PH_WB_SCL0  = 5'd4;
  localparam logic [4:0] PH_WB_BIT   = 5'd5;
  localparam logic [4:0] PH_WB_HI    = 5'd6;
  localparam logic [4:0] PH_WB_LO    = 5'd7;
  localparam logic [4:0] PH_WB_REL   = 5'd8;
  localparam logic [4:0] PH_ACK_HI   = 5'd9;
  localparam logic [4:0] PH_ACK_WAIT = 5'd10;
  localparam logic [4:0] PH_ACK_LO   = 5'd11;
  localparam logic [4:0] PH_RB_SCL0  = 5'd12;
  localparam logic [4:0] PH_RB_REL   = 5'd13;
  localparam logic [4:0] PH_RB_HI    = 5'd14;
  localparam logic [4:0] PH_RB_LO    = 5'd15;
  localparam logic [4:0] PH_SP_SDA0  = 5'd16;
  localparam logic [4:0] PH_SP_SCL1  = 5'd17;
  localparam logic [4:0] PH_SP_SDA1  = 5'd18;

  logic [6:0] dev_addr_r;
  logic [7:0] ack_limit_r;

  logic [4:0] phase_r, phase_nxt;
  logic [3:0] bit_cnt_r, bit_cnt_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [2:0] byte_step_r, byte_step_nxt;
  logic [7:0] wait_cnt_r, wait_cnt_nxt;
  logic       is_read_r, is_read_nxt;
  logic [7:0] addr_r, addr_nxt;
  logic [7:0] data_r, data_nxt;
  logic       miss_r, miss_nxt;
  logic [7:0] result_r, result_nxt;
  logic       scl_r, scl_nxt;
  logic       sda_r, sda_nxt;
  logic       done;

  logic                           out_valid_r, out_valid_nxt;
  logic [iea_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [iea_pkg::OUT_DATA_W-1:0] res_word;

  iea_pkg::tick_t t;
  logic [3:0]     bit_inc;
  logic [2:0]     step_inc;

  function automatic logic [7:0] byte_sel(input logic [2:0] step, input logic rd,
                                          input logic [6:0] dev, input logic [7:0] a,
                                          input logic [7:0] d);
    logic [7:0] r;
    if (step == 3'd0) begin
      r = {dev, 1'b0};
    end else if (step == 3'd1) begin
      r = a;
    end else if (rd) begin
      r = {dev, 1'b1};
    end else begin
      r = d;
    end
    return r;
  endfunction

  assign t        = q_head.item;
  assign q_pop    = q_head.valid && (!out_valid_r || out_tready);
  assign bit_inc  = bit_cnt_r + 4'd1;
  assign step_inc = byte_step_r + 3'd1;

  always_comb begin
    phase_nxt     = phase_r;
    bit_cnt_nxt   = bit_cnt_r;
    shift_nxt     = shift_r;
    byte_step_nxt = byte_step_r;
    wait_cnt_nxt  = wait_cnt_r;
    is_read_nxt   = is_read_r;
    addr_nxt      = addr_r;
    data_nxt      = data_r;
    miss_nxt      = miss_r;
    result_nxt    = result_r;
    scl_nxt       = scl_r;
    sda_nxt       = sda_r;
    done          = 1'b0;
    unique case (phase_r)
      PH_IDLE: begin
        if (t.kind == iea_pkg::CMD_WRITE || t.kind == iea_pkg::CMD_READ) begin
          is_read_nxt   = (t.kind == iea_pkg::CMD_READ);
          addr_nxt      = t.address;
          data_nxt      = t.write_data;
          miss_nxt      = 1'b0;
          byte_step_nxt = 3'd0;
          bit_cnt_nxt   = 4'd0;
          phase_nxt     = PH_ST_SDA1;
        end
      end
      PH_ST_SDA1: begin
        sda_nxt   = 1'b1;
        phase_nxt = PH_ST_SCL1;
      end
      PH_ST_SCL1: begin
        scl_nxt   = 1'b1;
        phase_nxt = PH_ST_SDA0;
      end
      PH_ST_SDA0: begin
        sda_nxt   = 1'b0;
        shift_nxt = byte_sel(byte_step_r, is_read_r, dev_addr_r, addr_r, data_r);
        phase_nxt = PH_WB_SCL0;
      end
      PH_WB_SCL0: begin
        scl_nxt     = 1'b0;
        bit_cnt_nxt = 4'd0;
        phase_nxt   = PH_WB_BIT;
      end
      PH_WB_BIT: begin
        sda_nxt   = shift_r[7];
        shift_nxt = {shift_r[6:0], 1'b0};
        phase_nxt = PH_WB_HI;
      end
      PH_WB_HI: begin
        scl_nxt   = 1'b1;
        phase_nxt = PH_WB_LO;
      end
      PH_WB_LO: begin
        scl_nxt     = 1'b0;
        bit_cnt_nxt = bit_inc;
        phase_nxt   = (bit_inc >= 4'd8) ? PH_WB_REL : PH_WB_BIT;
      end
      PH_WB_REL: begin
        sda_nxt   = 1'b1;
        phase_nxt = PH_ACK_HI;
      end
      PH_ACK_HI: begin
        scl_nxt      = 1'b1;
        wait_cnt_nxt = 8'd0;
        phase_nxt    = PH_ACK_WAIT;
      end
      PH_ACK_WAIT: begin
        if (!t.sda_in) begin
          phase_nxt = PH_ACK_LO;
        end else if (wait_cnt_r >= ack_limit_r) begin
          miss_nxt  = 1'b1;
          phase_nxt = PH_ACK_LO;
        end else begin
          wait_cnt_nxt = wait_cnt_r + 8'd1;
        end
      end
      PH_ACK_LO: begin
        scl_nxt       = 1'b0;
        byte_step_nxt = step_inc;
        if (is_read_r) begin
          if (step_inc == 3'd2) begin
            phase_nxt = PH_ST_SDA1;
          end else if (step_inc >= 3'd3) begin
            phase_nxt = PH_RB_SCL0;
          end else begin
            phase_nxt = PH_WB_SCL0;
          end
        end else begin
          phase_nxt = (step_inc >= 3'd3) ? PH_SP_SDA0 : PH_WB_SCL0;
        end
        if (phase_nxt == PH_WB_SCL0) begin
          shift_nxt = byte_sel(step_inc, is_read_r, dev_addr_r, addr_r, data_r);
        end
      end
      PH_RB_SCL0: begin
        scl_nxt   = 1'b0;
        phase_nxt = PH_RB_REL;
      end
      PH_RB_REL: begin
        sda_nxt     = 1'b1;
        bit_cnt_nxt = 4'd0;
        shift_nxt   = 8'd0;
        phase_nxt   = PH_RB_HI;
      end
      PH_RB_HI: begin
        scl_nxt   = 1'b1;
        shift_nxt = {shift_r[6:0], t.sda_in};
        phase_nxt = PH_RB_LO;
      end
      PH_RB_LO: begin
        scl_nxt     = 1'b0;
        bit_cnt_nxt = bit_inc;
        if (bit_inc >= 4'd8) begin
          result_nxt = shift_r;
          phase_nxt  = PH_SP_SDA0;
        end else begin
          phase_nxt = PH_RB_HI;
        end
      end
      PH_SP_SDA0: begin
        sda_nxt   = 1'b0;
        phase_nxt = PH_SP_SCL1;
      end
      PH_SP_SCL1: begin
        scl_nxt   = 1'b1;
        phase_nxt = PH_SP_SDA1;
      end
      PH_SP_SDA1: begin
        sda_nxt   = 1'b1;
        done      = 1'b1;
        phase_nxt = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // result word of this tick, highest field first
  assign res_word = {3'b000, miss_nxt, result_nxt, done, (phase_nxt != PH_IDLE),
                     sda_nxt, scl_nxt};

  assign out_valid_nxt = q_pop ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= res_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r  <= iea_pkg::DEV_ADDR_RST;
      ack_limit_r <= iea_pkg::ACK_LIMIT_RST;
      phase_r     <= PH_IDLE;
      bit_cnt_r   <= 4'd0;
      shift_r     <= 8'd0;
      byte_step_r <= 3'd0;
      wait_cnt_r  <= 8'd0;
      is_read_r   <= 1'b0;
      addr_r      <= 8'd0;
      data_r      <= 8'd0;
      miss_r      <= 1'b0;
      result_r    <= 8'd0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == iea_pkg::CFG_DEV_ADDR) begin
          dev_addr_r <= cfg_data[6:0];
        end else begin
          ack_limit_r <= cfg_data;
        end
      end
      if (q_pop) begin
        phase_r     <= phase_nxt;
        bit_cnt_r   <= bit_cnt_nxt;
        shift_r     <= shift_nxt;
        byte_step_r <= byte_step_nxt;
        wait_cnt_r  <= wait_cnt_nxt;
        is_read_r   <= is_read_nxt;
        addr_r      <= addr_nxt;
        data_r      <= data_nxt;
        miss_r      <= miss_nxt;
        result_r    <= result_nxt;
        scl_r       <= scl_nxt;
        sda_r       <= sda_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: hw/rtl/i2c_eeprom_access_master_unit.sv
// an accepted tick request waits in the front queue; its result is registered in the output slot when it is popped
// throughput: one tick request per cycle while the result channel is ready, one result per request
// the front queue holds two requests so intake keeps going while a result waits
// the bus sequencer steps its phase machine once per request; a full access spans many ticks
// reset (rst_n low, synchronous): idle phase, both bus lines released, queue
// emptied, device address 80 and acknowledge wait limit 250
module i2c_eeprom_access_master_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // tick request channel
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [7:0] address, [15:8] write_data, [16] sda_in, [23:17] zero
  input  logic [iea_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] func
  input  logic [iea_pkg::IN_USER_W-1:0]     in_tuser,
  // result channel
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [0] scl_out, [1] sda_release, [2] busy_res, [3] done_res,
  // [11:4] read_data, [12] ack_missing, [15:13] zero
  output logic [iea_pkg::OUT_DATA_W-1:0]    out_tdata,
  // register write channel: index 0 device_address, 1 ack_wait_limit
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [iea_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [iea_pkg::CFG_DATA_W-1:0]    cfg_data
);

  iea_pkg::q_head_t q_head;
  logic             q_pop;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // intake and classification of func codes, then the short queue
  iea_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_head    (q_head),
    .q_pop     (q_pop)
  );

  // phase machine and output register; pops only when the result slot frees up
  iea_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: hw/rtl/iea_checker.sv
// port-level checks for the i2c eeprom access master
module iea_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [iea_pkg::OUT_DATA_W-1:0]    out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  // nothing comes out straight after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // done only on the tick that returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3] |-> !out_tdata[2])
    else $error("done while still busy");

  // when idle both lines are released
  a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> out_tdata[0] && out_tdata[1])
    else $error("bus line held while idle");

endmodule

bind i2c_eeprom_access_master_unit iea_checker u_iea_checker (.*);
